@@ rtl/core/lpht_pkg.sv @@
// ============================================================================
// lpht_pkg
// Shared widths, codes and control structs of the linear-probe hash table.
// ============================================================================
package lpht_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int HASH_W   = 32;
   localparam int VALUE_W  = 32;
   localparam int MARK_W   = 2;
   localparam int COUNT_W  = 7;

   // hash reduction works one hex digit per cycle
   localparam int DIGIT_W  = 4;
   localparam int DIGITS   = HASH_W / DIGIT_W;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_DROP   = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_ENTRIES = 1'd0;
   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 7'd48;

   typedef struct packed {
      logic [MARK_W-1:0]  mark;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_word_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic probe_first;
      logic probe_step;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic slot_ready;
      logic probe_done;
   } status_type;

endpackage

@@ rtl/core/linear_probe_hash_table.sv @@
// ============================================================================
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// ============================================================================
// Usage:
//   Request channel: drive req_op (insert, get, drop), req_key_id,
//   req_key_hash and req_value_in with start high; the item is taken at the
//   clock edge where busy is low. busy stays high until its result is out.
//   Result channel: rsp_valid pulses for one cycle with rsp_hit,
//   rsp_value_out and rsp_status; the receiver must take it then, as it
//   cannot stall the block.
//   Sequence: after acceptance the start slot is formed, then slots are
//   probed in order, one slot per read of the slot store, then the result
//   is written back. With a capacity that is not a power of two, the start
//   slot is reduced one hex digit a cycle. The result strobe comes in the
//   last busy cycle; busy is low in the cycle after it.
//   Reset: clears the controller and the fill count, then sweeps the slot
//   store to empty, one slot a cycle, up to the last slot, with busy high.
//   Configuration: max_entries at byte address 0, written over the APB
//   port while no item is in flight; writes are taken during the sweep too.
// ============================================================================
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [KEY_W-1:0]      req_key_id,
   input  logic [HASH_W-1:0]     req_key_hash,
   input  logic [VALUE_W-1:0]    req_value_in,
   // result channel
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [VALUE_W-1:0]    rsp_value_out,
   output logic                  rsp_status,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type    cmd;
   status_type status;

   logic [COUNT_W-1:0] max_entries_ff, max_entries_in;
   logic               csr_wr;
   logic               csr_hit;

   // register file: a single load-limit register, word-addressed
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_MAX_ENTRIES);
   assign csr_wr  = psel & penable & pwrite;

   always_comb begin
      max_entries_in = max_entries_ff;
      if (csr_wr && csr_hit) begin
         max_entries_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else begin
         max_entries_ff <= max_entries_in;
      end
   end

   // read back the limit; anything else reads as zero
   assign prdata = csr_hit ? {{(CSR_DATA_W-COUNT_W){1'b0}}, max_entries_ff} : '0;
   assign pready = 1'b1;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lpht_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .max_entries   (max_entries_ff),
      .req_op        (req_op),
      .req_key_id    (req_key_id),
      .req_key_hash  (req_key_hash),
      .req_value_in  (req_value_in),
      .rsp_hit       (rsp_hit),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status)
   );

endmodule

@@ rtl/core/lpht_slot_mod.sv @@
// ============================================================================
// lpht_slot_mod
// Start slot: key hash reduced modulo the capacity.
// A power-of-two capacity is a mask; any other goes one hex digit a cycle.
// ============================================================================
module lpht_slot_mod
   import lpht_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [HASH_W-1:0]           hash,
   output logic                        done,
   output logic [$clog2(CAPACITY)-1:0] slot
);

   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic [SLOT_W-1:0] slot_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               slot_ff <= '0;
            end else if (start) begin
               slot_ff <= hash[SLOT_W-1:0];
            end
         end

         assign done = 1'b1;
         assign slot = slot_ff;
      end else begin : g_digit
         localparam int X_W   = SLOT_W + DIGIT_W;
         localparam int CNT_W = $clog2(DIGITS + 1);

         logic [HASH_W-1:0] hash_ff, hash_in;
         logic [SLOT_W-1:0] rem_ff, rem_in;
         logic [CNT_W-1:0]  cnt_ff, cnt_in;
         logic [X_W-1:0]    x;
         logic [X_W-1:0]    sub;

         // remainder stays below CAPACITY, so x < 16*CAPACITY
         always_comb begin
            x   = {rem_ff, hash_ff[HASH_W-1 -: DIGIT_W]};
            sub = '0;
            for (int k = 1; k < (1 << DIGIT_W); k++) begin
               if (x >= X_W'(k * CAPACITY)) begin
                  sub = X_W'(k * CAPACITY);
               end
            end
         end

         always_comb begin
            hash_in = hash_ff;
            rem_in  = rem_ff;
            cnt_in  = cnt_ff;
            if (start) begin
               hash_in = hash;
               rem_in  = '0;
               cnt_in  = CNT_W'(DIGITS);
            end else if (cnt_ff != '0) begin
               hash_in = hash_ff << DIGIT_W;
               rem_in  = SLOT_W'(x - sub);
               cnt_in  = cnt_ff - 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_in;
            end
            hash_ff <= hash_in;
            rem_ff  <= rem_in;
         end

         assign done = (cnt_ff == '0);
         assign slot = rem_ff;
      end
   endgenerate

endmodule

@@ rtl/core/lpht_dpath.sv @@
// ============================================================================
// lpht_dpath
// Slot store, probe walker, outcome registers and result formation.
// ============================================================================
module lpht_dpath
   import lpht_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [COUNT_W-1:0]   max_entries,
   input  logic [OP_W-1:0]      req_op,
   input  logic [KEY_W-1:0]     req_key_id,
   input  logic [HASH_W-1:0]    req_key_hash,
   input  logic [VALUE_W-1:0]   req_value_in,
   output logic                 rsp_hit,
   output logic [VALUE_W-1:0]   rsp_value_out,
   output logic                 rsp_status
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   slot_word_type mem [CAPACITY];
   slot_word_type rdata_ff;

   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [SLOT_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0]  scan_ff, scan_in;
   logic               tomb_seen_ff, tomb_seen_in;
   logic [SLOT_W-1:0]  tomb_at_ff, tomb_at_in;
   logic [COUNT_W-1:0] used_ff, used_in;

   logic               found_ff, slot_ok_ff, at_empty_ff;
   logic [SLOT_W-1:0]  at_ff;
   logic [VALUE_W-1:0] fval_ff;

   logic              start_done;
   logic [SLOT_W-1:0] start_slot;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] next_pos;

   logic              is_live, is_empty, is_tomb, match, last, done;
   logic              ev_slot_ok, ev_at_empty;
   logic [SLOT_W-1:0] ev_at;

   logic               we, fin_we;
   logic [SLOT_W-1:0]  waddr;
   slot_word_type      wdata, fin_wdata;
   logic               count_ok;

   lpht_slot_mod #(
      .CAPACITY (CAPACITY)
   ) u_slot_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.accept),
      .hash  (req_key_hash),
      .done  (start_done),
      .slot  (start_slot)
   );

   // ---- probe evaluation on the slot whose word sits in rdata_ff
   assign next_pos = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   always_comb begin
      is_live  = (rdata_ff.mark == MARK_LIVE);
      is_empty = (rdata_ff.mark == MARK_EMPTY);
      is_tomb  = (rdata_ff.mark == MARK_TOMB);
      match    = is_live && (rdata_ff.key == key_ff);
      last     = (scan_ff == LAST_SLOT);
      done     = match || is_empty || last;

      ev_slot_ok  = match || is_empty || tomb_seen_ff || is_tomb;
      ev_at_empty = !match && is_empty && !tomb_seen_ff;
      if (match) begin
         ev_at = pos_ff;
      end else if (tomb_seen_ff) begin
         ev_at = tomb_at_ff;
      end else begin
         ev_at = pos_ff;
      end
   end

   // keep one read in flight per cycle; reads past the decision are harmless
   always_comb begin
      rd_en        = cmd.probe_first | cmd.probe_step;
      rd_addr      = cmd.probe_first ? start_slot : next_pos;
      pos_in       = rd_en ? rd_addr : pos_ff;
      scan_in      = scan_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_at_in   = tomb_at_ff;
      if (cmd.probe_first) begin
         scan_in      = '0;
         tomb_seen_in = 1'b0;
      end else if (cmd.probe_step) begin
         scan_in = scan_ff + 1'b1;
         if (is_tomb && !tomb_seen_ff) begin
            tomb_seen_in = 1'b1;
            tomb_at_in   = pos_ff;
         end
      end
   end

   // ---- completion: write back and form the result
   assign count_ok = ({1'b0, used_ff} + (COUNT_W+1)'(1)) <= {1'b0, max_entries};

   always_comb begin
      fin_we          = 1'b0;
      fin_wdata.mark  = MARK_LIVE;
      fin_wdata.key   = key_ff;
      fin_wdata.value = value_ff;
      rsp_hit         = 1'b0;
      rsp_value_out   = '0;
      rsp_status      = 1'b0;
      used_in         = used_ff;
      case (op_ff)
         OP_INSERT: begin
            if (found_ff) begin
               fin_we = 1'b1;
            end else if (!slot_ok_ff) begin
               rsp_status = 1'b1;
            end else if (at_empty_ff && !count_ok) begin
               rsp_status = 1'b1;
            end else begin
               fin_we  = 1'b1;
               rsp_hit = 1'b1;
               if (at_empty_ff) begin
                  used_in = used_ff + 1'b1;
               end
            end
         end
         OP_GET: begin
            rsp_hit = found_ff;
            if (found_ff) begin
               rsp_value_out = fval_ff;
            end
         end
         OP_DROP: begin
            if (found_ff) begin
               fin_we          = 1'b1;
               rsp_hit         = 1'b1;
               fin_wdata.mark  = MARK_TOMB;
               fin_wdata.value = fval_ff;
            end
         end
         default: begin
         end
      endcase
      if (!cmd.finish) begin
         fin_we  = 1'b0;
         used_in = used_ff;
      end
   end

   always_comb begin
      we     = cmd.clear_step | fin_we;
      waddr  = cmd.clear_step ? clr_ff : at_ff;
      wdata  = fin_wdata;
      clr_in = clr_ff;
      if (cmd.clear_step) begin
         wdata.mark = MARK_EMPTY;
         clr_in     = clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         used_ff <= '0;
      end else begin
         clr_ff  <= clr_in;
         used_ff <= used_in;
      end
      pos_ff       <= pos_in;
      scan_ff      <= scan_in;
      tomb_seen_ff <= tomb_seen_in;
      tomb_at_ff   <= tomb_at_in;
      if (cmd.accept) begin
         op_ff    <= req_op;
         key_ff   <= req_key_id;
         value_ff <= req_value_in;
      end
      if (cmd.probe_step) begin
         found_ff    <= match;
         slot_ok_ff  <= ev_slot_ok;
         at_empty_ff <= ev_at_empty;
         at_ff       <= ev_at;
         fval_ff     <= rdata_ff.value;
      end
   end

   assign status.clear_last = (clr_ff == LAST_SLOT);
   assign status.slot_ready = start_done;
   assign status.probe_done = done;

endmodule

@@ rtl/core/lpht_ctrl.sv @@
// ============================================================================
// lpht_ctrl
// Sequencer: clearing pass, hash reduction wait, probe walk, completion.
// ============================================================================
module lpht_ctrl
   import lpht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [ST_W-1:0] ST_HASH   = 3'd2;
   localparam logic [ST_W-1:0] ST_PROBE  = 3'd3;
   localparam logic [ST_W-1:0] ST_FINISH = 3'd4;

   logic [ST_W-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            if (status.slot_ready) begin
               cmd.probe_first = 1'b1;
               state_in        = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.probe_step = 1'b1;
            if (status.probe_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_FINISH);

endmodule
